FILE: hdl/hcva_pkg.sv
`default_nettype none

package hcva_pkg;

    localparam int FUNC_W   = 2;
    localparam int COORD_W  = 8;
    localparam int RADIUS_W = 8;
    localparam int DIM_W    = 9;
    localparam int COUNT_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int PT_W     = 10;
    localparam int ERR_W    = 12;

    typedef logic [FUNC_W-1:0]    func_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [COUNT_W-1:0]   count_t;

    localparam func_t FUNC_CLEAR = 2'd0;
    localparam func_t FUNC_VOTE  = 2'd1;
    localparam func_t FUNC_READ  = 2'd2;

    localparam cfg_idx_t CFG_RADIUS = 2'd0;
    localparam cfg_idx_t CFG_WIDTH  = 2'd1;
    localparam cfg_idx_t CFG_HEIGHT = 2'd2;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 8'd1;
    localparam logic [DIM_W-1:0]    WIDTH_RESET  = 9'd256;
    localparam logic [DIM_W-1:0]    HEIGHT_RESET = 9'd256;

    localparam count_t COUNT_MAX = 16'hFFFF;

endpackage

`default_nettype wire

FILE: hdl/hough_circle_vote_accumulator_core.sv
`default_nettype none

// Read: vote_count is registered in S_READ once the output is free; then back to S_IDLE.
// Vote: busy through S_AXIS, S_STEP, S_EMIT and S_NEXT, visiting every circle point
//   (clipped points included), each column decrement and each row, then S_DRAIN.
// Clear: one accumulator cell per cycle, MAX_HEIGHT * 2**clog2(MAX_WIDTH) cells in all.
// Reset: registers take their reset values and the same clearing sweep runs
//   before the first item is accepted; configuration writes are taken throughout.
module hough_circle_vote_accumulator_core #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_RADIUS = 255
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire hcva_pkg::cfg_idx_t                cfg_index,
    input  wire logic [hcva_pkg::DIM_W-1:0]        cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire hcva_pkg::func_t                   func,
    input  wire logic [hcva_pkg::COORD_W-1:0]      pos_x,
    input  wire logic [hcva_pkg::COORD_W-1:0]      pos_y,
    input  wire logic [hcva_pkg::COORD_W-1:0]      pixel_value,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output hcva_pkg::count_t                       vote_count
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int AW    = CW + RW;
    localparam int DEPTH = MAX_HEIGHT * (1 << CW);
    localparam int PW    = hcva_pkg::PT_W;
    localparam int EW    = hcva_pkg::ERR_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_AXIS  = 3'd3;
    localparam logic [2:0] S_STEP  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;
    localparam logic [2:0] S_NEXT  = 3'd6;
    localparam logic [2:0] S_DRAIN = 3'd7;

    logic [2:0]                          state_reg;
    logic [hcva_pkg::RADIUS_W-1:0]       radius_reg;
    logic [hcva_pkg::DIM_W-1:0]          width_reg;
    logic [hcva_pkg::DIM_W-1:0]          height_reg;
    logic [hcva_pkg::COORD_W-1:0]        cx_reg;
    logic [hcva_pkg::COORD_W-1:0]        cy_reg;
    logic [hcva_pkg::RADIUS_W-1:0]       row_reg;
    logic [hcva_pkg::RADIUS_W-1:0]       col_reg;
    logic signed [EW-1:0]                e_reg;
    logic [2:0]                          k_reg;
    logic [AW-1:0]                       clr_addr_reg;
    logic                                wr_pend_reg;
    logic [AW-1:0]                       wr_addr_reg;
    logic                                byp_reg;
    hcva_pkg::count_t                    byp_data_reg;
    logic                                rd_zero_reg;
    logic                                out_valid_reg;
    hcva_pkg::count_t                    vote_count_reg;

    logic [hcva_pkg::DIM_W-1:0]          eff_w;
    logic [hcva_pkg::DIM_W-1:0]          eff_h;
    logic                                in_xfer;
    logic                                vote_ok;
    logic                                read_in_range;
    logic [hcva_pkg::RADIUS_W-1:0]       off_a;
    logic [hcva_pkg::RADIUS_W-1:0]       off_b;
    logic signed [PW-1:0]                ox;
    logic signed [PW-1:0]                oy;
    logic signed [PW-1:0]                pt_x;
    logic signed [PW-1:0]                pt_y;
    logic                                pt_active;
    logic                                pt_in;
    logic                                emit_en;
    logic signed [EW-1:0]                addend;
    logic signed [EW-1:0]                e_sum;
    logic [hcva_pkg::RADIUS_W:0]         row_inc;
    hcva_pkg::count_t                    cur_count;
    hcva_pkg::count_t                    inc_count;
    logic                                out_free;

    logic                                ram_we;
    logic [AW-1:0]                       ram_waddr;
    hcva_pkg::count_t                    ram_wdata;
    logic                                ram_re;
    logic [AW-1:0]                       ram_raddr;
    hcva_pkg::count_t                    ram_rdata;

    assign eff_w = (32'(width_reg) > MAX_WIDTH) ? hcva_pkg::DIM_W'(MAX_WIDTH) : width_reg;
    assign eff_h = (32'(height_reg) > MAX_HEIGHT) ? hcva_pkg::DIM_W'(MAX_HEIGHT) : height_reg;

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign vote_ok  = (pixel_value != '0) && (radius_reg != '0)
                      && (32'(radius_reg) <= MAX_RADIUS);
    assign read_in_range = (32'(pos_x) < MAX_WIDTH) && (32'(pos_y) < MAX_HEIGHT);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        off_a = '0;
        off_b = '0;
        ox    = '0;
        oy    = '0;
        if (state_reg == S_AXIS)
        begin
            case (k_reg[1:0])
                2'd0:    ox = $signed({2'b00, radius_reg});
                2'd1:    ox = -$signed({2'b00, radius_reg});
                2'd2:    oy = $signed({2'b00, radius_reg});
                default: oy = -$signed({2'b00, radius_reg});
            endcase
        end
        else
        begin
            off_a = k_reg[2] ? row_reg : col_reg;
            off_b = k_reg[2] ? col_reg : row_reg;
            ox = k_reg[0] ? -$signed({2'b00, off_a}) : $signed({2'b00, off_a});
            oy = k_reg[1] ? -$signed({2'b00, off_b}) : $signed({2'b00, off_b});
        end
    end

    assign pt_x      = $signed({2'b00, cx_reg}) + ox;
    assign pt_y      = $signed({2'b00, cy_reg}) + oy;
    assign pt_active = (state_reg == S_AXIS) || (state_reg == S_EMIT);
    assign pt_in     = !pt_x[PW-1] && (pt_x[hcva_pkg::DIM_W-1:0] < eff_w)
                       && !pt_y[PW-1] && (pt_y[hcva_pkg::DIM_W-1:0] < eff_h);
    assign emit_en   = pt_active && pt_in;

    // shared error-term adder: column step adds 2*col-2, row step subtracts 2*row+1
    assign addend = (state_reg == S_STEP) ? ($signed({3'b000, col_reg, 1'b0}) - EW'(2))
                                          : ~$signed({3'b000, row_reg, 1'b0});
    assign e_sum   = e_reg + addend;
    assign row_inc = {1'b0, row_reg} + 1'b1;

    assign cur_count = byp_reg ? byp_data_reg : ram_rdata;
    assign inc_count = (cur_count == hcva_pkg::COUNT_MAX) ? cur_count : cur_count + 1'b1;

    always_comb
    begin
        ram_re    = emit_en;
        ram_raddr = {RW'(pt_y[hcva_pkg::DIM_W-1:0]), CW'(pt_x[hcva_pkg::DIM_W-1:0])};
        if (state_reg == S_IDLE)
        begin
            ram_re    = in_xfer && (func == hcva_pkg::FUNC_READ) && read_in_range;
            ram_raddr = {RW'(pos_y), CW'(pos_x)};
        end
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = wr_pend_reg;
            ram_waddr = wr_addr_reg;
            ram_wdata = inc_count;
        end
    end

    hcva_ram #(
        .DATA_W (hcva_pkg::COUNT_W),
        .DEPTH  (DEPTH)
    ) u_acc_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= hcva_pkg::RADIUS_RESET;
            width_reg  <= hcva_pkg::WIDTH_RESET;
            height_reg <= hcva_pkg::HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                hcva_pkg::CFG_RADIUS: radius_reg <= cfg_data[hcva_pkg::RADIUS_W-1:0];
                hcva_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                hcva_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            k_reg         <= '0;
            wr_pend_reg   <= 1'b0;
            byp_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_pend_reg <= emit_en;
            byp_reg     <= emit_en && wr_pend_reg && (wr_addr_reg == ram_raddr);
            if ((state_reg == S_READ) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == AW'(DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    k_reg        <= '0;
                    clr_addr_reg <= '0;
                    if (in_xfer)
                    begin
                        unique case (func)
                            hcva_pkg::FUNC_CLEAR: state_reg <= S_CLEAR;
                            hcva_pkg::FUNC_VOTE:
                            begin
                                if (vote_ok)
                                begin
                                    state_reg <= S_AXIS;
                                end
                            end
                            hcva_pkg::FUNC_READ:  state_reg <= S_READ;
                            default: ;
                        endcase
                    end
                end
                S_READ:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_AXIS:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == 3'd3)
                    begin
                        state_reg <= (radius_reg > 8'd1) ? S_STEP : S_DRAIN;
                    end
                end
                S_STEP:
                begin
                    if (!e_reg[EW-1])
                    begin
                        k_reg     <= '0;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    k_reg <= k_reg + 1'b1;
                    if ((k_reg == 3'd7) || ((k_reg == 3'd3) && (col_reg == row_reg)))
                    begin
                        state_reg <= S_NEXT;
                    end
                end
                S_NEXT:
                begin
                    state_reg <= (row_inc < {1'b0, col_reg}) ? S_STEP : S_DRAIN;
                end
                S_DRAIN:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg  <= ram_raddr;
        byp_data_reg <= inc_count;
        if (in_xfer)
        begin
            cx_reg      <= pos_x;
            cy_reg      <= pos_y;
            rd_zero_reg <= !read_in_range;
        end
        if ((state_reg == S_READ) && out_free)
        begin
            vote_count_reg <= rd_zero_reg ? '0 : ram_rdata;
        end
        unique case (state_reg)
            S_AXIS:
            begin
                row_reg <= 8'd1;
                col_reg <= radius_reg;
                e_reg   <= $signed({4'b0000, radius_reg}) - EW'(1);
            end
            S_STEP:
            begin
                if (e_reg[EW-1])
                begin
                    col_reg <= col_reg - 1'b1;
                    e_reg   <= e_sum;
                end
            end
            S_NEXT:
            begin
                row_reg <= row_inc[hcva_pkg::RADIUS_W-1:0];
                e_reg   <= e_sum;
            end
            default: ;
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign vote_count = vote_count_reg;

`ifndef SYNTHESIS
    a_no_rmw_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> (state_reg != S_CLEAR))
        else $error("increment write overlaps clear sweep");

    a_emit_err_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (!e_reg[EW-1] && (col_reg != '0)))
        else $error("circle point emitted with unsettled column");

    a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_READ))
        else $error("result raised without a read");

    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_IDLE) && ($past(state_reg) == S_IDLE)) |-> !wr_pend_reg)
        else $error("increment pending while idle");

    a_read_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == S_READ) |-> ($past(state_reg) == S_IDLE))
        else $error("read entered from a busy state");
`endif

endmodule

`default_nettype wire

FILE: hdl/hcva_ram.sv
`default_nettype none

module hcva_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_W = 256;
    localparam int GRID_H = 256;
    localparam int RADIUS_CAP = 255;
    localparam hcva_pkg::func_t FUNC_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 2000;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PHASES = 9;
    localparam int PHASE_ITEMS = 38;

    typedef struct {
        hcva_pkg::count_t count;
        int               x;
        int               y;
    } cell_read_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_write = 1'b0;
    hcva_pkg::cfg_idx_t             cfg_index = hcva_pkg::CFG_RADIUS;
    logic [hcva_pkg::DIM_W-1:0]     cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    hcva_pkg::func_t                func = hcva_pkg::FUNC_CLEAR;
    logic [hcva_pkg::COORD_W-1:0]   pos_x = '0;
    logic [hcva_pkg::COORD_W-1:0]   pos_y = '0;
    logic [hcva_pkg::COORD_W-1:0]   pixel_value = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    hcva_pkg::count_t               vote_count;

    bit [hcva_pkg::COUNT_W-1:0]     vote_grid [GRID_W*GRID_H];
    bit [hcva_pkg::RADIUS_W-1:0]    radius_set = hcva_pkg::RADIUS_RESET;
    bit [hcva_pkg::DIM_W-1:0]       width_set = hcva_pkg::WIDTH_RESET;
    bit [hcva_pkg::DIM_W-1:0]       height_set = hcva_pkg::HEIGHT_RESET;
    cell_read_t                     pending_reads [$];
    int                             recent_x [$];
    int                             recent_y [$];

    bit                   calm = 1'b0;
    int                   mismatches = 0;
    int                   reads_checked = 0;
    int                   n_votes = 0;
    int                   n_clears = 0;
    int                   n_ignored = 0;
    int                   n_settings = 0;
    int                   cycle_count = 0;

    hough_circle_vote_accumulator_core #(
        .MAX_WIDTH  (GRID_W),
        .MAX_HEIGHT (GRID_H),
        .MAX_RADIUS (RADIUS_CAP)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pixel_value (pixel_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .vote_count  (vote_count)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic void bump_cell(int c, int r, int lim_w, int lim_h);
        int idx;
        if (c < 0 || c >= lim_w || r < 0 || r >= lim_h)
            return;
        idx = r * GRID_W + c;
        if (vote_grid[idx] != hcva_pkg::COUNT_MAX)
            vote_grid[idx] = vote_grid[idx] + 1'b1;
    endfunction

    function automatic void tally_circle(int cx, int cy);
        int rad;
        int row;
        int col;
        int lim_w;
        int lim_h;
        rad = int'(radius_set);
        lim_w = (int'(width_set) > GRID_W) ? GRID_W : int'(width_set);
        lim_h = (int'(height_set) > GRID_H) ? GRID_H : int'(height_set);
        if (rad == 0 || rad > RADIUS_CAP)
            return;
        bump_cell(cx + rad, cy, lim_w, lim_h);
        bump_cell(cx - rad, cy, lim_w, lim_h);
        bump_cell(cx, cy + rad, lim_w, lim_h);
        bump_cell(cx, cy - rad, lim_w, lim_h);
        col = rad;
        for (row = 1; row < col; row++)
        begin
            while (col * col > rad * rad - row * row + col)
                col--;
            bump_cell(cx + col, cy + row, lim_w, lim_h);
            bump_cell(cx - col, cy + row, lim_w, lim_h);
            bump_cell(cx + col, cy - row, lim_w, lim_h);
            bump_cell(cx - col, cy - row, lim_w, lim_h);
            if (col != row)
            begin
                bump_cell(cx + row, cy + col, lim_w, lim_h);
                bump_cell(cx - row, cy + col, lim_w, lim_h);
                bump_cell(cx + row, cy - col, lim_w, lim_h);
                bump_cell(cx - row, cy - col, lim_w, lim_h);
            end
        end
    endfunction

    function automatic int isqrt(int v);
        int s;
        s = 0;
        while ((s + 1) * (s + 1) <= v)
            s++;
        return s;
    endfunction

    function automatic logic [hcva_pkg::COORD_W-1:0] clamp_coord(int v);
        if (v < 0)
            return '0;
        if (v > GRID_W - 1)
            return '1;
        return v[hcva_pkg::COORD_W-1:0];
    endfunction

    function automatic logic [hcva_pkg::COORD_W-1:0] any_coord();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            return '0;
        if (sel < 20)
            return '1;
        return hcva_pkg::COORD_W'($urandom_range(0, GRID_W - 1));
    endfunction

    function automatic logic [hcva_pkg::DIM_W-1:0] pick_dim();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 5)
            return '0;
        if (sel < 20)
            return hcva_pkg::DIM_W'($urandom_range(1, 16));
        if (sel < 35)
            return hcva_pkg::DIM_W'($urandom_range(257, 511));
        if (sel < 55)
            return hcva_pkg::DIM_W'(GRID_W);
        return hcva_pkg::DIM_W'($urandom_range(1, 256));
    endfunction

    task automatic send_item(input hcva_pkg::func_t f, input logic [hcva_pkg::COORD_W-1:0] x,
                             input logic [hcva_pkg::COORD_W-1:0] y,
                             input logic [hcva_pkg::COORD_W-1:0] pv);
        int gap;
        if (!calm && $urandom_range(0, 99) < 10)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        func <= f;
        pos_x <= x;
        pos_y <= y;
        pixel_value <= pv;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        case (f)
            hcva_pkg::FUNC_CLEAR:
            begin
                foreach (vote_grid[i])
                    vote_grid[i] = '0;
                n_clears++;
            end
            hcva_pkg::FUNC_VOTE:
            begin
                if (pv != '0)
                begin
                    tally_circle(int'(x), int'(y));
                    recent_x.push_back(int'(x));
                    recent_y.push_back(int'(y));
                    if (recent_x.size() > 8)
                    begin
                        void'(recent_x.pop_front());
                        void'(recent_y.pop_front());
                    end
                    n_votes++;
                end
                else
                    n_ignored++;
            end
            hcva_pkg::FUNC_READ:
                pending_reads.push_back(cell_read_t'{
                    count: vote_grid[int'(y) * GRID_W + int'(x)],
                    x: int'(x), y: int'(y)});
            default:
                n_ignored++;
        endcase
    endtask

    task automatic program_setup(input logic [hcva_pkg::RADIUS_W-1:0] r,
                                 input logic [hcva_pkg::DIM_W-1:0] w,
                                 input logic [hcva_pkg::DIM_W-1:0] h);
        cfg_write <= 1'b1;
        cfg_index <= hcva_pkg::CFG_RADIUS;
        cfg_data <= hcva_pkg::DIM_W'(r);
        @(posedge clk);
        cfg_index <= hcva_pkg::CFG_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_index <= hcva_pkg::CFG_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_write <= 1'b0;
        radius_set = r;
        width_set = w;
        height_set = h;
        recent_x.delete();
        recent_y.delete();
        n_settings++;
    endtask

    // drain outstanding reads, then let any trailing vote finish
    task automatic finish_phase();
        in_valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic read_near_circle();
        int j;
        int rad;
        int dx;
        int dy;
        rad = int'(radius_set);
        if (recent_x.size() == 0 || rad == 0 || $urandom_range(0, 3) == 0)
            send_item(hcva_pkg::FUNC_READ, any_coord(), any_coord(),
                      hcva_pkg::COORD_W'($urandom_range(0, 255)));
        else
        begin
            j = $urandom_range(0, recent_x.size() - 1);
            dx = int'($urandom_range(0, 2 * rad)) - rad;
            dy = isqrt(rad * rad - dx * dx) + int'($urandom_range(0, 2)) - 1;
            if ($urandom_range(0, 1))
                dy = -dy;
            send_item(hcva_pkg::FUNC_READ, clamp_coord(recent_x[j] + dx),
                      clamp_coord(recent_y[j] + dy),
                      hcva_pkg::COORD_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_cleared_on_reset();
        send_item(hcva_pkg::FUNC_READ, 8'd0, 8'd0, 8'd0);
        send_item(hcva_pkg::FUNC_READ, 8'd255, 8'd255, 8'hFF);
        finish_phase();
    endtask

    task automatic test_unit_radius();
        send_item(hcva_pkg::FUNC_VOTE, 8'd0, 8'd0, 8'hFF);
        send_item(hcva_pkg::FUNC_VOTE, 8'd255, 8'd255, 8'h01);
        send_item(hcva_pkg::FUNC_VOTE, 8'd128, 8'd128, 8'h80);
        send_item(hcva_pkg::FUNC_VOTE, 8'd100, 8'd100, 8'h00);
        send_item(FUNC_SPARE, 8'd1, 8'd0, 8'hFF);
        send_item(hcva_pkg::FUNC_READ, 8'd1, 8'd0, 8'd0);
        send_item(hcva_pkg::FUNC_READ, 8'd0, 8'd1, 8'd0);
        send_item(hcva_pkg::FUNC_READ, 8'd255, 8'd254, 8'd0);
        send_item(hcva_pkg::FUNC_READ, 8'd127, 8'd128, 8'd0);
        send_item(hcva_pkg::FUNC_READ, 8'd128, 8'd127, 8'd0);
        send_item(hcva_pkg::FUNC_READ, 8'd101, 8'd100, 8'd0);
        finish_phase();
    endtask

    task automatic test_largest_radius();
        program_setup(8'd255, 9'd256, 9'd256);
        send_item(hcva_pkg::FUNC_VOTE, 8'd0, 8'd0, 8'h7F);
        send_item(hcva_pkg::FUNC_VOTE, 8'd255, 8'd255, 8'h55);
        send_item(hcva_pkg::FUNC_READ, 8'd255, 8'd0, 8'd0);
        send_item(hcva_pkg::FUNC_READ, 8'd0, 8'd255, 8'd0);
        send_item(hcva_pkg::FUNC_READ, 8'd180, 8'd180, 8'd0);
        finish_phase();
    endtask

    task automatic test_dimension_clipping();
        program_setup(8'd3, 9'd511, 9'd1);
        send_item(hcva_pkg::FUNC_VOTE, 8'd254, 8'd0, 8'hAA);
        send_item(hcva_pkg::FUNC_READ, 8'd251, 8'd0, 8'd0);
        finish_phase();
        program_setup(8'd2, 9'd0, 9'd0);
        send_item(hcva_pkg::FUNC_VOTE, 8'd5, 8'd5, 8'hFF);
        send_item(hcva_pkg::FUNC_READ, 8'd7, 8'd5, 8'd0);
        finish_phase();
        program_setup(8'd0, 9'd1, 9'd256);
        send_item(hcva_pkg::FUNC_VOTE, 8'd0, 8'd5, 8'h01);
        send_item(hcva_pkg::FUNC_READ, 8'd0, 8'd5, 8'd0);
        finish_phase();
    endtask

    task automatic test_clear_all();
        send_item(hcva_pkg::FUNC_CLEAR, 8'd17, 8'd200, 8'h3C);
        send_item(hcva_pkg::FUNC_READ, 8'd255, 8'd0, 8'd0);
        finish_phase();
    endtask

    task automatic test_random_traffic();
        int p;
        int k;
        int pick;
        logic [hcva_pkg::RADIUS_W-1:0] r_new;
        logic [hcva_pkg::COORD_W-1:0] hot_x;
        logic [hcva_pkg::COORD_W-1:0] hot_y;
        logic [hcva_pkg::COORD_W-1:0] vx;
        logic [hcva_pkg::COORD_W-1:0] vy;
        logic [hcva_pkg::COORD_W-1:0] pv;
        for (p = 0; p < PHASES; p++)
        begin
            calm = (p == 4);
            if (p == 2)
                r_new = hcva_pkg::RADIUS_W'($urandom_range(200, 255));
            else if ($urandom_range(0, 9) == 0)
                r_new = '0;
            else
                r_new = hcva_pkg::RADIUS_W'($urandom_range(1, 40));
            program_setup(r_new, pick_dim(), pick_dim());
            hot_x = hcva_pkg::COORD_W'($urandom_range(0, 255));
            hot_y = hcva_pkg::COORD_W'($urandom_range(0, 255));
            for (k = 0; k < PHASE_ITEMS - 1; k++)
            begin
                pick = $urandom_range(0, 99);
                if (p == 5 && k == PHASE_ITEMS / 2)
                    send_item(hcva_pkg::FUNC_CLEAR, any_coord(), any_coord(),
                              hcva_pkg::COORD_W'($urandom_range(0, 255)));
                else if (pick < 55)
                begin
                    if ($urandom_range(0, 99) < 70)
                    begin
                        vx = clamp_coord(int'(hot_x) + int'($urandom_range(0, 12)) - 6);
                        vy = clamp_coord(int'(hot_y) + int'($urandom_range(0, 12)) - 6);
                    end
                    else
                    begin
                        vx = any_coord();
                        vy = any_coord();
                    end
                    pv = ($urandom_range(0, 99) < 8) ? 8'd0 : 8'($urandom_range(1, 255));
                    send_item(hcva_pkg::FUNC_VOTE, vx, vy, pv);
                end
                else if (pick < 95)
                    read_near_circle();
                else
                    send_item(FUNC_SPARE, any_coord(), any_coord(),
                              hcva_pkg::COORD_W'($urandom_range(0, 255)));
            end
            read_near_circle();
            finish_phase();
        end
        calm = 1'b0;
    endtask

    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < 10);

    always @(posedge clk)
    begin : result_check
        cell_read_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reads.size() == 0)
            begin
                $display("%0t: transfer with no read outstanding, vote_count %0d",
                         $time, vote_count);
                mismatches++;
            end
            else
            begin
                want = pending_reads.pop_front();
                reads_checked++;
                if (vote_count !== want.count)
                begin
                    $display("%0t: vote_count at (%0d,%0d) expected %0d actual %0d",
                             $time, want.x, want.y, want.count, vote_count);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_cleared_on_reset();
        test_unit_radius();
        test_largest_radius();
        test_dimension_clipping();
        test_clear_all();
        test_random_traffic();
        $display("Covered %0d circle votes, %0d clears and %0d ignored items",
                 n_votes, n_clears, n_ignored);
        $display("across %0d register settings; %0d cell reads compared",
                 n_settings, reads_checked);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
hdl/hcva_pkg.sv
hdl/hcva_ram.sv
hdl/hough_circle_vote_accumulator_core.sv
sim/tb_top.sv
